@@ sv/assert_macros.svh @@
// Assertion macros shared by the layer normalisation RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ sv/lnr_pkg.sv @@
// Types and constants shared by the layer normalisation row block
`timescale 1ns / 1ps
package lnr_pkg;

  localparam int DataW  = 16;
  localparam int DivNumW = 64;
  localparam int DivDenW = 32;

  typedef struct packed {
    logic signed [DataW-1:0] sample;
    logic signed [DataW-1:0] gain;
    logic signed [DataW-1:0] offset;
  } lnr_item_t;

  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    row_end;
  } lnr_result_t;

  typedef enum logic [0:0] {
    CFG_ROW_LENGTH = 1'b0,
    CFG_EPSILON    = 1'b1
  } lnr_cfg_idx_e;

  typedef struct packed {
    logic load;
    logic mean_go;
    logic var_go;
    logic inv_go;
    logic mean_take;
    logic var_take;
    logic inv_take;
    logic acc_clr;
    logic rd;
    logic dev;
    logic sq;
    logic acc;
    logic sqrt_step;
    logic mlo;
    logic mhi;
    logic norm;
    logic mg;
    logic emit;
    logic row_clr;
  } lnr_cmd_t;

  typedef struct packed {
    logic div_done;
    logic row_done;
    logic at_last;
  } lnr_status_t;

endpackage

@@ sv/lnr_ram.sv @@
// Generic single-port-write, registered-read RAM
`timescale 1ns / 1ps
module lnr_ram #(
  parameter int Width = 48,
  parameter int Depth = 64,
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lnr_div.sv @@
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lnr_div
  import lnr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DivNumW-1:0] quot_o
);

  localparam int CntW = $clog2(DivNumW);

  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q;
  logic [CntW-1:0]    cnt_q;
  logic               busy_q, done_q;
  logic [DivDenW:0]   trial, diff;
  logic               ge;

  always_comb begin
    trial = {rem_q, quo_q[DivNumW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DivDenW-1:0] : trial[DivDenW-1:0];
    quo_d = {quo_q[DivNumW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DivNumW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  `ASSERT_PROP(a_done_after_busy, done_q |-> $past(busy_q), "divider done without work")

endmodule

@@ sv/lnr_datapath.sv @@
// Datapath: row store, statistics, square root, normalise and scale
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lnr_datapath
  import lnr_pkg::*;
#(
  parameter int MaxRow = 64,
  localparam int AW = (MaxRow > 1) ? $clog2(MaxRow) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lnr_cmd_t      cmd_i,
  input  logic [AW-1:0] addr_i,
  output lnr_status_t   status_o,
  input  logic          cfg_we_i,
  input  logic [0:0]    cfg_index_i,
  input  logic [15:0]   cfg_data_i,
  input  lnr_item_t     item_i,
  output logic          result_valid_o,
  output lnr_result_t   result_o
);

  localparam int FW = $clog2(MaxRow + 1);
  localparam logic [6:0] MaxLen = 7'(MaxRow);

  logic [6:0]  row_len_q;
  logic [15:0] eps_q;
  logic [FW-1:0] fill_q;
  logic [23:0] sum_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= 7'd64;
      eps_q     <= 16'd1;
    end else if (cfg_we_i) begin
      case (lnr_cfg_idx_e'(cfg_index_i))
        CFG_ROW_LENGTH: row_len_q <= cfg_data_i[6:0];
        CFG_EPSILON:    eps_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // row completion
  logic [6:0] len_eff, fill_next;
  always_comb begin
    len_eff = row_len_q;
    if (row_len_q == 7'd0) len_eff = 7'd1;
    else if (row_len_q > MaxLen) len_eff = MaxLen;
    fill_next = 7'(fill_q) + 7'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.row_clr) begin
      fill_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.load) begin
      fill_q <= fill_q + 1'b1;
      sum_q  <= sum_q + {{8{item_i.sample[15]}}, item_i.sample};
    end
  end

  logic [FW-1:0] fill_m1;
  assign fill_m1 = fill_q - 1'b1;

  // row store
  lnr_item_t rd_item;
  logic [$bits(lnr_item_t)-1:0] rd_bits;
  lnr_ram #(.Width($bits(lnr_item_t)), .Depth(MaxRow)) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load),
    .waddr_i (AW'(fill_q)),
    .wdata_i (item_i),
    .re_i    (cmd_i.rd),
    .raddr_i (addr_i),
    .rdata_o (rd_bits)
  );
  assign rd_item = lnr_item_t'(rd_bits);

  // shared divider
  logic [31:0] n32, sum_mag, mean_num, root_nz;
  logic [DivNumW-1:0] div_num, quot;
  logic [DivDenW-1:0] div_den;
  logic div_go, div_busy, div_done;
  logic [63:0] sumsq_q, sq_q;
  logic [63:0] srem_q, sroot_q, sbit_q;

  always_comb begin
    n32      = 32'(fill_q);
    sum_mag  = 32'(sum_q[23] ? (24'd0 - sum_q) : sum_q);
    mean_num = (sum_mag << 8) + (n32 >> 1);
    root_nz  = (sroot_q == 64'd0) ? 32'd1 : sroot_q[31:0];
    div_go   = cmd_i.mean_go | cmd_i.var_go | cmd_i.inv_go;
    div_num  = 64'h0000_0100_0000_0000;
    div_den  = root_nz;
    if (cmd_i.mean_go) begin
      div_num = {32'd0, mean_num};
      div_den = n32;
    end else if (cmd_i.var_go) begin
      div_num = sumsq_q;
      div_den = n32;
    end
  end

  lnr_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (div_num),
    .den_i  (div_den),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (quot)
  );

  // statistics, square root and element arithmetic
  logic [32:0] mean_q;
  logic [40:0] inv_q;
  lnr_item_t   elem_q;
  logic [31:0] dmag_q, norm_q;
  logic        dneg_q, qneg_q;
  logic [55:0] plo_q;
  logic [48:0] phi_q;
  logic [47:0] q_q;

  logic [33:0] dval, dabs;
  logic [63:0] strial;
  logic [72:0] psum;
  logic [15:0] gmag;
  logic [47:0] qrnd;
  logic [25:0] ys, ytot;
  logic [15:0] ysat;

  always_comb begin
    dval   = {{10{rd_item.sample[15]}}, rd_item.sample, 8'h00} - {mean_q[32], mean_q};
    dabs   = dval[33] ? (34'd0 - dval) : dval;
    strial = sroot_q + sbit_q;
    psum   = {17'd0, plo_q} + {phi_q, 24'd0} + 73'h80_0000;
    gmag   = elem_q.gain[15] ? (16'd0 - elem_q.gain) : elem_q.gain;
    qrnd   = q_q + 48'h8000;
    ys     = qneg_q ? (26'd0 - {2'b00, qrnd[39:16]}) : {2'b00, qrnd[39:16]};
    ytot   = ys + {{10{elem_q.offset[15]}}, elem_q.offset};
    // clamp to the signed output range
    if (!ytot[25] && (ytot[24:15] != 10'd0)) ysat = 16'h7FFF;
    else if (ytot[25] && (ytot[24:15] != 10'h3FF)) ysat = 16'h8000;
    else ysat = ytot[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mean_take) begin
      mean_q <= sum_q[23] ? (33'd0 - {1'b0, quot[31:0]}) : {1'b0, quot[31:0]};
    end
    if (cmd_i.acc_clr) sumsq_q <= '0;
    else if (cmd_i.acc) sumsq_q <= sumsq_q + sq_q;
    if (cmd_i.dev) begin
      elem_q <= rd_item;
      dmag_q <= dabs[31:0];
      dneg_q <= dval[33];
    end
    if (cmd_i.sq) sq_q <= dmag_q * dmag_q;
    if (cmd_i.var_take) begin
      srem_q  <= quot + {32'd0, eps_q, 16'd0};
      sroot_q <= '0;
      sbit_q  <= 64'h4000_0000_0000_0000;
    end else if (cmd_i.sqrt_step) begin
      if (srem_q >= strial) begin
        srem_q  <= srem_q - strial;
        sroot_q <= (sroot_q >> 1) + sbit_q;
      end else begin
        sroot_q <= sroot_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
    if (cmd_i.inv_take) inv_q <= quot[40:0];
    if (cmd_i.mlo) plo_q <= dmag_q * inv_q[23:0];
    if (cmd_i.mhi) phi_q <= dmag_q * inv_q[40:24];
    if (cmd_i.norm) norm_q <= psum[55:24];
    if (cmd_i.mg) begin
      q_q    <= norm_q * gmag;
      qneg_q <= dneg_q ^ elem_q.gain[15];
    end
    if (cmd_i.emit) begin
      result_o.value   <= ysat;
      result_o.row_end <= status_o.at_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else result_valid_o <= cmd_i.emit;
  end

  always_comb begin
    status_o.div_done = div_done;
    status_o.row_done = fill_next >= len_eff;
    status_o.at_last  = addr_i == AW'(fill_m1);
  end

  `ASSERT_NEVER(a_div_go_busy, div_go && div_busy, "divider restarted while busy")

endmodule

@@ sv/lnr_ctrl.sv @@
// Controller: sequences load, statistics, root and output passes
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lnr_ctrl
  import lnr_pkg::*;
#(
  parameter int MaxRow = 64,
  localparam int AW = (MaxRow > 1) ? $clog2(MaxRow) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  lnr_status_t   status_i,
  output lnr_cmd_t      cmd_o,
  output logic [AW-1:0] addr_o
);

  typedef enum logic [18:0] {
    S_IDLE      = 19'h00001,
    S_MEAN_GO   = 19'h00002,
    S_MEAN_WAIT = 19'h00004,
    S_V_RD      = 19'h00008,
    S_V_DEV     = 19'h00010,
    S_V_SQ      = 19'h00020,
    S_V_ACC     = 19'h00040,
    S_VDIV_GO   = 19'h00080,
    S_VDIV_WAIT = 19'h00100,
    S_SQRT      = 19'h00200,
    S_INV_GO    = 19'h00400,
    S_INV_WAIT  = 19'h00800,
    S_O_RD      = 19'h01000,
    S_O_DEV     = 19'h02000,
    S_O_MLO     = 19'h04000,
    S_O_MHI     = 19'h08000,
    S_O_NORM    = 19'h10000,
    S_O_MG      = 19'h20000,
    S_O_EMIT    = 19'h40000
  } lnr_state_e;

  lnr_state_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [4:0]    iter_q, iter_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    iter_d  = iter_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
        if (start_i && status_i.row_done) state_d = S_MEAN_GO;
      end
      S_MEAN_GO: begin
        cmd_o.mean_go = 1'b1;
        cmd_o.acc_clr = 1'b1;
        state_d       = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.mean_take = 1'b1;
          idx_d           = '0;
          state_d         = S_V_RD;
        end
      end
      S_V_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_V_DEV;
      end
      S_V_DEV: begin
        cmd_o.dev = 1'b1;
        state_d   = S_V_SQ;
      end
      S_V_SQ: begin
        cmd_o.sq = 1'b1;
        state_d  = S_V_ACC;
      end
      S_V_ACC: begin
        cmd_o.acc = 1'b1;
        if (status_i.at_last) begin
          idx_d   = '0;
          state_d = S_VDIV_GO;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_V_RD;
        end
      end
      S_VDIV_GO: begin
        cmd_o.var_go = 1'b1;
        state_d      = S_VDIV_WAIT;
      end
      S_VDIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.var_take = 1'b1;
          iter_d         = '0;
          state_d        = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        iter_d          = iter_q + 1'b1;
        if (iter_q == 5'd31) state_d = S_INV_GO;
      end
      S_INV_GO: begin
        cmd_o.inv_go = 1'b1;
        state_d      = S_INV_WAIT;
      end
      S_INV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.inv_take = 1'b1;
          idx_d          = '0;
          state_d        = S_O_RD;
        end
      end
      S_O_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_O_DEV;
      end
      S_O_DEV: begin
        cmd_o.dev = 1'b1;
        state_d   = S_O_MLO;
      end
      S_O_MLO: begin
        cmd_o.mlo = 1'b1;
        state_d   = S_O_MHI;
      end
      S_O_MHI: begin
        cmd_o.mhi = 1'b1;
        state_d   = S_O_NORM;
      end
      S_O_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_O_MG;
      end
      S_O_MG: begin
        cmd_o.mg = 1'b1;
        state_d  = S_O_EMIT;
      end
      S_O_EMIT: begin
        cmd_o.emit = 1'b1;
        if (status_i.at_last) begin
          cmd_o.row_clr = 1'b1;
          state_d       = S_IDLE;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_O_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      iter_q  <= iter_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign addr_o = idx_q;

  `ASSERT_PROP(a_partial_row_idle,
    (state_q == S_IDLE && start_i && !status_i.row_done) |=> state_q == S_IDLE,
    "left idle on an incomplete row")
  `ASSERT_PROP(a_last_emit_idle,
    (state_q == S_O_EMIT && status_i.at_last) |=> state_q == S_IDLE,
    "row did not end after its last result")

endmodule

@@ sv/layer_normalization_row.sv @@
// Layer normalisation over one row: top level
// Usage:
//   Input channel: present one element (sample, gain, offset, Q7.8) on item_i
//   with start_i high; the transfer happens on a rising edge while busy_o is
//   low. Elements of an incomplete row are taken one per cycle.
//   The element that completes the row (row_length elements) raises busy_o.
//   The block then runs a mean division, a variance pass that reads, takes
//   the deviation of, squares and accumulates each element, a variance
//   division, a 32-step square root and a reciprocal division, the three
//   divisions on one shared bit-serial divider.
//   Results: result_valid_o strobes one cycle per element, in row order;
//   row_end marks the last. The receiver cannot stall results.
//   busy_o falls as the last result is shown; the next row may start then.
//   Config: cfg_we_i writes row_length (index 0) or epsilon (index 1); write
//   only while idle. Reset clears the partial row and restores row_length 64
//   and epsilon 1.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module layer_normalization_row
  import lnr_pkg::*;
#(
  parameter int MAX_ROW = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  lnr_item_t   item_i,
  output logic        result_valid_o,
  output lnr_result_t result_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int AW = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;

  lnr_cmd_t      cmd;
  lnr_status_t   status;
  logic [AW-1:0] addr;

  lnr_ctrl #(.MaxRow(MAX_ROW)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .busy_o   (busy_o),
    .status_i (status),
    .cmd_o    (cmd),
    .addr_o   (addr)
  );

  lnr_datapath #(.MaxRow(MAX_ROW)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .addr_i         (addr),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  `ASSERT_PROP(a_idle_result_is_last, (result_valid_o && !busy_o) |-> result_o.row_end,
    "result shown while idle is not the row end")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the layer normalisation row block
`timescale 1ns / 1ps
module testbench;
  import lnr_pkg::*;

  localparam int CycleLimit = 600000;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  lnr_item_t   item_i;
  logic        result_valid_o;
  lnr_result_t result_o;
  logic        cfg_we_i;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  layer_normalization_row DUT (.*);

  // num / den, nearest, ties away from zero
  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned b;
    rem = v;
    root = 0;
    b = 64'h4000_0000_0000_0000;
    for (int k = 0; k < 32; k++) begin
      if (rem >= root + b) begin
        rem -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  class norm_scoreboard;
    int unsigned       row_len = 64;
    longint unsigned   eps = 1;
    longint            samp_q[$];
    longint            gain_q[$];
    longint            ofs_q[$];
    logic signed [23:0] row_sum = '0;
    lnr_result_t       expected_q[$];
    int unsigned       errors = 0;

    function void set_config(lnr_cfg_idx_e idx, logic [15:0] d);
      if (idx == CFG_ROW_LENGTH) row_len = int'(d[6:0]);
      else eps = 64'(d);
    endfunction

    function void note_element(lnr_item_t it);
      int unsigned       len;
      int unsigned       n;
      longint            mean;
      longint            d;
      longint unsigned   a;
      longint unsigned   sumsq;
      longint unsigned   root;
      longint unsigned   inv;
      longint            norm;
      longint            y;
      lnr_result_t       r;
      samp_q.push_back(longint'(it.sample));
      gain_q.push_back(longint'(it.gain));
      ofs_q.push_back(longint'(it.offset));
      row_sum = row_sum + 24'(signed'(it.sample));
      len = (row_len == 0) ? 1 : (row_len > 64) ? 64 : row_len;
      if (samp_q.size() < len) return;
      n = samp_q.size();
      mean = round_div(longint'(row_sum) * 256, n);
      sumsq = 0;
      foreach (samp_q[i]) begin
        d = samp_q[i] * 256 - mean;
        a = (d < 0) ? longint'(-d) : longint'(d);
        sumsq += a * a;
      end
      root = floor_sqrt(sumsq / n + (eps << 16));
      if (root == 0) root = 1;
      inv = (64'd1 << 40) / root;
      foreach (samp_q[i]) begin
        d = samp_q[i] * 256 - mean;
        norm = round_div(d * longint'(inv), 64'd1 << 24);
        y = round_div(norm * gain_q[i], 64'd1 << 16) + ofs_q[i];
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        r.value = y[15:0];
        r.row_end = (i == n - 1);
        expected_q.push_back(r);
      end
      samp_q.delete();
      gain_q.delete();
      ofs_q.delete();
      row_sum = '0;
    endfunction

    function void check_result(lnr_result_t r);
      lnr_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value %0d row_end %0b", $time, r.value, r.row_end);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (r.value !== e.value) begin
        $display("%0t: value expected %0d actual %0d", $time, e.value, r.value);
        errors++;
      end
      if (r.row_end !== e.row_end) begin
        $display("%0t: row_end expected %0b actual %0b", $time, e.row_end, r.row_end);
        errors++;
      end
    endfunction
  endclass

  norm_scoreboard sb;
  int unsigned    accepted;
  int unsigned    cycles;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("layer_normalization_row regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check_result(result_o);
  end

  task automatic send_element(logic [15:0] s, logic [15:0] g, logic [15:0] o);
    int unsigned idle_pct;
    idle_pct = (accepted >= 120 && accepted < 180) ? 0 : 26;
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i <= 1'b1;
    item_i  <= '{sample: s, gain: g, offset: o};
    do @(posedge clk_i); while (busy_o);
    sb.note_element('{sample: s, gain: g, offset: o});
    accepted++;
  endtask

  // hold off until every result has come and the block is quiet
  task automatic wait_quiet();
    start_i <= 1'b0;
    do @(posedge clk_i); while (busy_o || sb.expected_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(lnr_cfg_idx_e idx, logic [15:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_config(idx, d);
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned rl;
    int unsigned eff;
    int unsigned mode;
    int unsigned rows;
    logic [15:0] level;
    logic [15:0] s;
    sb = new();
    accepted = 0;
    cycles = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-element rows: output is the offset
    write_reg(CFG_ROW_LENGTH, 16'd1);
    send_element(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_element(16'h8000, 16'h8000, 16'h8000);
    send_element(16'h0000, 16'h0000, 16'h0000);
    wait_quiet();
    write_reg(CFG_ROW_LENGTH, 16'd4);
    send_element(16'h7FFF, 16'h7FFF, 16'h0000);
    send_element(16'h8000, 16'h8000, 16'h7FFF);
    send_element(16'h0001, 16'hFFFF, 16'h8000);
    send_element(16'h0000, 16'h5555, 16'hAAAA);
    wait_quiet();
    // constant row with no stabiliser: zero root
    write_reg(CFG_EPSILON, 16'd0);
    write_reg(CFG_ROW_LENGTH, 16'd3);
    repeat (3) send_element(16'h0064, 16'h0100, 16'h0010);
    wait_quiet();
    // zero row length behaves as one
    write_reg(CFG_EPSILON, 16'hFFFF);
    write_reg(CFG_ROW_LENGTH, 16'd0);
    send_element(16'h1234, 16'hF00D, 16'h0BEE);
    wait_quiet();
    // lower the row length mid-row: next element closes the row
    write_reg(CFG_ROW_LENGTH, 16'd8);
    repeat (5) send_element(16'($urandom), 16'($urandom), 16'($urandom));
    wait_quiet();
    write_reg(CFG_ROW_LENGTH, 16'd2);
    send_element(16'($urandom), 16'($urandom), 16'($urandom));
    wait_quiet();

    while (accepted < 215) begin
      case ($urandom_range(9))
        0: rl = 1;
        1: rl = 64;
        2: rl = 100;
        3: rl = 0;
        default: rl = $urandom_range(2, 12);
      endcase
      write_reg(CFG_ROW_LENGTH, 16'(rl));
      case ($urandom_range(3))
        0: write_reg(CFG_EPSILON, 16'd0);
        1: write_reg(CFG_EPSILON, 16'hFFFF);
        2: write_reg(CFG_EPSILON, 16'd1);
        default: write_reg(CFG_EPSILON, 16'($urandom));
      endcase
      eff = (rl == 0) ? 1 : (rl > 64) ? 64 : rl;
      rows = (eff > 16) ? 1 : $urandom_range(1, 4);
      repeat (rows) begin
        mode = $urandom_range(3);
        level = 16'($urandom);
        repeat (eff) begin
          case (mode)
            0: s = 16'($signed($urandom_range(1024)) - 512);
            1: s = level;
            default: s = 16'($urandom);
          endcase
          send_element(s, 16'($urandom), 16'($urandom));
        end
      end
      wait_quiet();
    end

    start_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("layer_normalization_row regression: pass");
    end else begin
      $display("layer_normalization_row regression: fail");
    end
    $finish;
  end

endmodule
